@@ design/mflsc_pkg.sv @@
// Shared types, codes and helpers of the MIX field load, store and compare unit.
package mflsc_pkg;

  localparam int unsigned MemWordsDefault = 4000;
  localparam int unsigned AddrWidth       = 12;
  localparam int unsigned ByteWidth       = 6;
  localparam int unsigned WordBytes       = 5;
  localparam int unsigned WordWidth       = ByteWidth * WordBytes;

  // Command codes.
  localparam logic [1:0] CmdLoad    = 2'd0;
  localparam logic [1:0] CmdLoadNeg = 2'd1;
  localparam logic [1:0] CmdStore   = 2'd2;
  localparam logic [1:0] CmdCompare = 2'd3;

  // Comparison codes.
  localparam logic [1:0] CmpLess    = 2'd0;
  localparam logic [1:0] CmpEqual   = 2'd1;
  localparam logic [1:0] CmpGreater = 2'd2;

  // Machine cycles charged for a performed operation.
  localparam logic [1:0] CostDone = 2'd2;

  typedef struct packed {
    logic [1:0]           command;
    logic [AddrWidth-1:0] address;
    logic [5:0]           field_spec;
    logic                 reg_sign;
    logic [WordWidth-1:0] reg_bytes;
    logic                 mem_sign;
    logic [WordWidth-1:0] mem_bytes;
  } req_t;

  typedef struct packed {
    logic                 new_reg_sign;
    logic [WordWidth-1:0] new_reg_bytes;
    logic                 reg_write;
    logic                 new_mem_sign;
    logic [WordWidth-1:0] new_mem_bytes;
    logic                 mem_write;
    logic [1:0]           compare_result;
    logic                 compare_valid;
    logic [1:0]           cycle_cost;
    logic                 field_error;
  } rsp_t;

  // Widens a per-byte select (bit 0 is byte 5) into a bit mask of the word.
  function automatic logic [WordWidth-1:0] expand_mask(input logic [WordBytes-1:0] sel);
    logic [WordWidth-1:0] m;
    m = '0;
    for (int k = 0; k < WordBytes; k++) begin
      m[k*ByteWidth +: ByteWidth] = {ByteWidth{sel[k]}};
    end
    return m;
  endfunction

endpackage

@@ design/mflsc_if.sv @@
// Request and response channel interfaces of the field unit.
interface mflsc_in_if;
  logic              valid;
  logic              ready;
  mflsc_pkg::req_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mflsc_out_if;
  logic              valid;
  logic              ready;
  mflsc_pkg::rsp_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ design/mix_field_load_store_compare_top.sv @@
// MIX field unit: load, load negative, store and compare on a partial word field.
// The unit is a three-stage pipeline: decode of the field spec and address
// check, then byte selection, alignment and store merge, then the signed
// comparison and the response register. It takes one request per cycle unless
// a stall has backed up to its input, and each response passes the stages in order;
// a response-side stall backs up stage by stage, and empty stages keep filling.
module mix_field_load_store_compare_top #(
  parameter int unsigned MemoryWords = mflsc_pkg::MemWordsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mflsc_in_if.sink             req_i,
  mflsc_out_if.source          rsp_o
);

  localparam int unsigned WW = mflsc_pkg::WordWidth;
  localparam int unsigned WB = mflsc_pkg::WordBytes;
  localparam int unsigned AW = mflsc_pkg::AddrWidth;

  // Stage advance: a stage loads when it is empty or its successor moves.
  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  assign en3 = !v3_q || rsp_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign req_i.ready = en1;

  // ---------------- stage 1: decode ----------------
  logic [2:0]    first, last, lo;
  logic          err_d, ok_d;
  logic [WB-1:0] bsel_d;
  logic [2:0]    sh_d;

  logic [1:0]    cmd1_q;
  logic          err1_q, ok1_q, fz1_q, rs1_q, ms1_q;
  logic [WB-1:0] bsel1_q;
  logic [2:0]    sh1_q;
  logic [WW-1:0] rb1_q, mb1_q;

  always_comb begin
    first  = req_i.payload.field_spec[5:3];
    last   = req_i.payload.field_spec[2:0];
    lo     = (first == 3'd0) ? 3'd1 : first;
    err_d  = (last > 3'd5) || (first > last);
    ok_d   = !err_d && ({1'b0, req_i.payload.address} < (AW+1)'(MemoryWords));
    sh_d   = 3'd5 - last;
    for (int k = 0; k < WB; k++) begin
      // bit k covers byte 5-k
      bsel_d[k] = (3'(WB - k) >= lo) && (3'(WB - k) <= last);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cmd1_q  <= req_i.payload.command;
      err1_q  <= err_d;
      ok1_q   <= ok_d;
      fz1_q   <= (first == 3'd0);
      bsel1_q <= bsel_d;
      sh1_q   <= sh_d;
      rs1_q   <= req_i.payload.reg_sign;
      ms1_q   <= req_i.payload.mem_sign;
      rb1_q   <= req_i.payload.reg_bytes;
      mb1_q   <= req_i.payload.mem_bytes;
    end
  end

  // ---------------- stage 2: select and align ----------------
  logic [WW-1:0] mask2;
  logic [4:0]    shamt2;
  logic [1:0]    cmd2_q;
  logic          err2_q, ok2_q, fz2_q, rs2_q, ms2_q;
  logic [WW-1:0] mfield2_q, rfield2_q, merged2_q;

  always_comb begin
    mask2  = mflsc_pkg::expand_mask(bsel1_q);
    shamt2 = ({2'b00, sh1_q} << 2) + ({2'b00, sh1_q} << 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      cmd2_q    <= cmd1_q;
      err2_q    <= err1_q;
      ok2_q     <= ok1_q;
      fz2_q     <= fz1_q;
      rs2_q     <= rs1_q;
      ms2_q     <= ms1_q;
      mfield2_q <= (mb1_q & mask2) >> shamt2;
      rfield2_q <= (rb1_q & mask2) >> shamt2;
      merged2_q <= (mb1_q & ~mask2) | ((rb1_q << shamt2) & mask2);
    end
  end

  // ---------------- stage 3: compare and respond ----------------
  mflsc_pkg::rsp_t rsp_d, rsp_q;
  logic            rneg, mneg, is_load, is_neg;
  logic [1:0]      cmp;

  always_comb begin
    // A zero magnitude is never negative, so -0 compares equal to +0.
    rneg = fz2_q && rs2_q && (rfield2_q != '0);
    mneg = fz2_q && ms2_q && (mfield2_q != '0);
    if (rneg != mneg) begin
      cmp = rneg ? mflsc_pkg::CmpLess : mflsc_pkg::CmpGreater;
    end else if (rfield2_q == mfield2_q) begin
      cmp = mflsc_pkg::CmpEqual;
    end else begin
      cmp = ((rfield2_q > mfield2_q) ^ rneg) ? mflsc_pkg::CmpGreater : mflsc_pkg::CmpLess;
    end

    is_load = (cmd2_q == mflsc_pkg::CmdLoad) || (cmd2_q == mflsc_pkg::CmdLoadNeg);
    is_neg  = (cmd2_q == mflsc_pkg::CmdLoadNeg);

    rsp_d             = '0;
    rsp_d.field_error = err2_q;
    if (ok2_q) begin
      rsp_d.cycle_cost = mflsc_pkg::CostDone;
      case (cmd2_q)
        mflsc_pkg::CmdLoad, mflsc_pkg::CmdLoadNeg: begin
          rsp_d.new_reg_sign  = fz2_q ? (ms2_q ^ is_neg) : is_neg;
          rsp_d.new_reg_bytes = mfield2_q;
          rsp_d.reg_write     = is_load;
        end
        mflsc_pkg::CmdStore: begin
          rsp_d.new_mem_sign  = fz2_q ? rs2_q : ms2_q;
          rsp_d.new_mem_bytes = merged2_q;
          rsp_d.mem_write     = 1'b1;
        end
        default: begin
          rsp_d.compare_result = cmp;
          rsp_d.compare_valid  = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid   = v3_q;
  assign rsp_o.payload = rsp_q;

endmodule

@@ design/mflsc_checker.sv @@
// Port-level assertions for the field unit and their binding to the top level.
module mflsc_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            rsp_valid_i,
  input logic            rsp_ready_i,
  input mflsc_pkg::rsp_t rsp_i
);

  // An invalid field spec never writes and is never charged.
  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_i.field_error |->
      !rsp_i.reg_write && !rsp_i.mem_write && !rsp_i.compare_valid &&
      (rsp_i.cycle_cost == 2'd0))
    else $error("field error response carries an effect");

  // At most one kind of effect per response.
  a_one_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> $onehot0({rsp_i.reg_write, rsp_i.mem_write, rsp_i.compare_valid}))
    else $error("more than one effect in a response");

  // The cost is charged exactly when an operation takes effect.
  a_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |->
      ((rsp_i.cycle_cost == mflsc_pkg::CostDone) ==
       (rsp_i.reg_write || rsp_i.mem_write || rsp_i.compare_valid)) &&
      ((rsp_i.cycle_cost == mflsc_pkg::CostDone) || (rsp_i.cycle_cost == 2'd0)))
    else $error("cycle cost does not match the effect");

  // A valid comparison is always one of the three codes.
  a_cmp_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_i.compare_valid |->
      (rsp_i.compare_result == mflsc_pkg::CmpLess) ||
      (rsp_i.compare_result == mflsc_pkg::CmpEqual) ||
      (rsp_i.compare_result == mflsc_pkg::CmpGreater))
    else $error("bad comparison code");

  // A stalled response holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_i))
    else $error("stalled response changed");

endmodule

bind mix_field_load_store_compare_top mflsc_checker u_mflsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_i       (rsp_o.payload)
);

@@ test/mix_field_load_store_compare_top_test.sv @@
// Self-checking testbench of the MIX field load, store and compare unit.
module mix_field_load_store_compare_top_test;
  import mflsc_pkg::*;

  localparam int unsigned MemWords = MemWordsDefault;

  logic clk_i = 1'b0;
  logic rst_ni;

  mflsc_in_if  req_if ();
  mflsc_out_if rsp_if ();

  mix_field_load_store_compare_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #2 clk_i = ~clk_i;

  req_t pending_reqs[$];
  rsp_t awaited_results[$];
  int   total_reqs = 0;
  int   accepted_count = 0;
  int   fail_count = 0;
  int   send_pause, send_calm, recv_pause, recv_calm;
  rsp_t want;

  // Expected response of the field unit to one request.
  function automatic rsp_t field_unit_result(input req_t r);
    rsp_t                 o;
    int unsigned          field_first, field_last, low_byte, nbytes, shift;
    logic [63:0]          wide_mask;
    logic [WordWidth-1:0] mask;
    longint               reg_val, mem_val;
    o = '0;
    field_first = 32'(r.field_spec[5:3]);
    field_last  = 32'(r.field_spec[2:0]);
    if (field_last > WordBytes || field_first > field_last) begin
      o.field_error = 1'b1;
      return o;
    end
    if (r.address >= MemWords) return o;
    low_byte  = (field_first == 0) ? 1 : field_first;
    nbytes    = (field_last >= low_byte) ? field_last - low_byte + 1 : 0;
    shift     = ByteWidth * (WordBytes - field_last);
    wide_mask = ((64'd1 << (ByteWidth * nbytes)) - 64'd1) << shift;
    mask      = wide_mask[WordWidth-1:0];
    case (r.command)
      CmdLoad, CmdLoadNeg: begin
        // An unsigned field loads as positive, or as negative for load negative.
        if (field_first == 0) o.new_reg_sign = r.mem_sign ^ (r.command == CmdLoadNeg);
        else o.new_reg_sign = (r.command == CmdLoadNeg);
        o.new_reg_bytes = (r.mem_bytes & mask) >> shift;
        o.reg_write = 1'b1;
      end
      CmdStore: begin
        o.new_mem_sign  = (field_first == 0) ? r.reg_sign : r.mem_sign;
        o.new_mem_bytes = (r.mem_bytes & ~mask) | ((r.reg_bytes << shift) & mask);
        o.mem_write = 1'b1;
      end
      default: begin
        reg_val = longint'((r.reg_bytes & mask) >> shift);
        mem_val = longint'((r.mem_bytes & mask) >> shift);
        if (field_first == 0) begin
          if (r.reg_sign) reg_val = -reg_val;
          if (r.mem_sign) mem_val = -mem_val;
        end
        if (reg_val > mem_val) o.compare_result = CmpGreater;
        else if (reg_val < mem_val) o.compare_result = CmpLess;
        else o.compare_result = CmpEqual;
        o.compare_valid = 1'b1;
      end
    endcase
    o.cycle_cost = CostDone;
    return o;
  endfunction

  function automatic req_t make_req(input logic [1:0] cmd, input logic [AddrWidth-1:0] addr,
                                    input logic [5:0] spec, input logic rs,
                                    input logic [WordWidth-1:0] rb, input logic ms,
                                    input logic [WordWidth-1:0] mb);
    req_t r;
    r.command    = cmd;
    r.address    = addr;
    r.field_spec = spec;
    r.reg_sign   = rs;
    r.reg_bytes  = rb;
    r.mem_sign   = ms;
    r.mem_bytes  = mb;
    return r;
  endfunction

  function automatic logic [WordWidth-1:0] random_bytes();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return WordWidth'($urandom_range(0, 63));
      default: return WordWidth'($urandom());
    endcase
  endfunction

  // Cycles to hold off before the next request or response; now and then a stretch with no gaps.
  function automatic int draw_pause(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      send_pause = 0;
      send_calm  = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        awaited_results.push_back(field_unit_result(req_if.payload));
        accepted_count++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_pause > 0) begin
          req_if.valid <= 1'b0;
          send_pause--;
        end else if (pending_reqs.size() != 0) begin
          req_if.valid   <= 1'b1;
          req_if.payload <= pending_reqs.pop_front();
          send_pause = draw_pause(send_calm);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      recv_pause = 0;
      recv_calm  = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected response %p", rsp_if.payload);
        end else begin
          want = awaited_results.pop_front();
          if (rsp_if.payload.new_reg_sign   !== want.new_reg_sign   ||
              rsp_if.payload.new_reg_bytes  !== want.new_reg_bytes  ||
              rsp_if.payload.reg_write      !== want.reg_write      ||
              rsp_if.payload.new_mem_sign   !== want.new_mem_sign   ||
              rsp_if.payload.new_mem_bytes  !== want.new_mem_bytes  ||
              rsp_if.payload.mem_write      !== want.mem_write      ||
              rsp_if.payload.compare_result !== want.compare_result ||
              rsp_if.payload.compare_valid  !== want.compare_valid  ||
              rsp_if.payload.cycle_cost     !== want.cycle_cost     ||
              rsp_if.payload.field_error    !== want.field_error) begin
            fail_count++;
            if (fail_count <= 10)
              $display("response mismatch: expected %p, got %p", want, rsp_if.payload);
          end
        end
        recv_pause = draw_pause(recv_calm);
      end
      if (recv_pause > 0) begin
        rsp_if.ready <= 1'b0;
        recv_pause--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [1:0]           cmd;
    logic [AddrWidth-1:0] addr;
    logic [5:0]           spec;
    int unsigned          lo_pick, hi_pick;
    logic [WordWidth-1:0] rb;
    // The falling reset edge puts the driver, the monitor and the unit into reset.
    rst_ni <= 1'b0;

    // Loads: full signed field, unsigned fields, single bytes and the sign alone.
    pending_reqs.push_back(make_req(CmdLoad, 12'd0, 6'o05, 1'b0, '0, 1'b1, '1));
    pending_reqs.push_back(make_req(CmdLoad, 12'd1, 6'o15, 1'b1, '1, 1'b1, 30'h2AAAAAAA));
    pending_reqs.push_back(make_req(CmdLoad, 12'd2, 6'o55, 1'b0, '0, 1'b0, 30'h15555555));
    pending_reqs.push_back(make_req(CmdLoad, 12'd3, 6'o00, 1'b0, '1, 1'b1, '1));
    pending_reqs.push_back(make_req(CmdLoadNeg, 12'd4, 6'o05, 1'b0, '0, 1'b0, 30'h12345678));
    pending_reqs.push_back(make_req(CmdLoadNeg, 12'd5, 6'o05, 1'b1, '1, 1'b1, 30'h0ABCDEF1));
    // Load negative of an unsigned field must come out negative.
    pending_reqs.push_back(make_req(CmdLoadNeg, 12'd6, 6'o23, 1'b0, '0, 1'b0, '1));
    // Stores into the last valid address and into various field shapes.
    pending_reqs.push_back(make_req(CmdStore, 12'd3999, 6'o05, 1'b1, '1, 1'b0, '0));
    pending_reqs.push_back(make_req(CmdStore, 12'd7, 6'o11, 1'b1, 30'h3F, 1'b1, '0));
    pending_reqs.push_back(make_req(CmdStore, 12'd8, 6'o34, 1'b0, 30'h0FFF, 1'b1, '0));
    pending_reqs.push_back(make_req(CmdStore, 12'd9, 6'o00, 1'b1, '0, 1'b0, '1));
    pending_reqs.push_back(make_req(CmdStore, 12'd10, 6'o55, 1'b0, '1, 1'b0, 30'h15555555));
    // Minus zero equals plus zero, and the sign-only field always compares equal.
    pending_reqs.push_back(make_req(CmdCompare, 12'd11, 6'o05, 1'b1, '0, 1'b0, '0));
    pending_reqs.push_back(make_req(CmdCompare, 12'd12, 6'o00, 1'b1, '1, 1'b0, '0));
    pending_reqs.push_back(make_req(CmdCompare, 12'd13, 6'o05, 1'b1, '1, 1'b0, 30'd1));
    pending_reqs.push_back(make_req(CmdCompare, 12'd14, 6'o05, 1'b0, 30'd1, 1'b1, '1));
    pending_reqs.push_back(make_req(CmdCompare, 12'd15, 6'o15, 1'b1, '1, 1'b0, 30'd1));
    pending_reqs.push_back(make_req(CmdCompare, 12'd16, 6'o33, 1'b0, 30'h0003F000, 1'b1,
                                    30'h0003F000));
    // Out-of-range addresses charge nothing, compare included.
    pending_reqs.push_back(make_req(CmdLoad, 12'd4000, 6'o05, 1'b1, '1, 1'b1, '1));
    pending_reqs.push_back(make_req(CmdCompare, 12'd4095, 6'o05, 1'b1, '1, 1'b0, '0));
    pending_reqs.push_back(make_req(CmdStore, 12'd2048, 6'o05, 1'b1, '1, 1'b0, '0));
    // Invalid fields: last byte beyond five, or first after last, at any address.
    pending_reqs.push_back(make_req(CmdLoad, 12'd0, 6'o06, 1'b1, '1, 1'b1, '1));
    pending_reqs.push_back(make_req(CmdStore, 12'd4095, 6'o77, 1'b1, '1, 1'b1, '1));
    pending_reqs.push_back(make_req(CmdCompare, 12'd20, 6'o32, 1'b1, '1, 1'b0, '1));
    pending_reqs.push_back(make_req(CmdLoadNeg, 12'd21, 6'o07, 1'b0, '0, 1'b1, '0));

    for (int i = 0; i < 2000; i++) begin
      cmd = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) addr = AddrWidth'($urandom_range(0, 4095));
      else addr = AddrWidth'($urandom_range(0, MemWords - 1));
      if ($urandom_range(0, 6) == 0) begin
        spec = 6'($urandom_range(0, 63));
      end else begin
        hi_pick = $urandom_range(0, WordBytes);
        lo_pick = $urandom_range(0, hi_pick);
        spec = {lo_pick[2:0], hi_pick[2:0]};
      end
      rb = random_bytes();
      pending_reqs.push_back(make_req(cmd, addr, spec, 1'($urandom()), rb, 1'($urandom()),
                                      ($urandom_range(0, 3) == 0) ? rb : random_bytes()));
    end
    total_reqs = pending_reqs.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_count < total_reqs) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("mix_field_load_store_compare_top_test passed");
    end else begin
      $display("mix_field_load_store_compare_top_test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("mix_field_load_store_compare_top_test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
design/mflsc_pkg.sv
design/mflsc_if.sv
design/mix_field_load_store_compare_top.sv
design/mflsc_checker.sv
test/mix_field_load_store_compare_top_test.sv
